@@ design/srpg_pkg.sv @@
package srpg_pkg;

	localparam int CFG_W     = 13;
	localparam int SPEED_W   = 10;
	localparam int TIME_W    = 32;
	localparam int TFRAC_W   = 10;
	localparam int FRAC_W    = 16;
	localparam int ADDR_W    = 2;

	localparam int SUM_W     = TIME_W + 1;
	localparam int YNUM_W    = SUM_W + FRAC_W;

	localparam int DIV_STAGES = 13;
	localparam int LATENCY    = DIV_STAGES + 6;

	localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = 13'd512;
	localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = 13'd512;
	localparam logic [SPEED_W-1:0] RST_SCROLL_SPEED = 10'd80;

	localparam logic [16:0] Q16_ONE  = 17'h10000;
	localparam logic [16:0] Q16_HALF = 17'h08000;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [ADDR_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_SCROLL_SPEED = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SECT_RED_GREEN_UP = 3'd0,
		SECT_RED_DOWN     = 3'd1,
		SECT_BLUE_UP      = 3'd2,
		SECT_GREEN_DOWN   = 3'd3,
		SECT_RED_UP       = 3'd4,
		SECT_BLUE_DOWN    = 3'd5
	} sector_t;

	function automatic logic [16:0] sat_entry(input int k, input int bits);
		longint unsigned quarter, quad, r, m, ang, a2, t, s, mag, res;
		quarter = 64'd1 << (bits - 2);
		quad    = (longint'(k) >> (bits - 2)) & 64'd3;
		r       = longint'(k) & (quarter - 64'd1);
		m       = quad[0] ? (quarter - r) : r;
		ang     = (m * 64'd6746518852) >> bits;
		a2      = (ang * ang) >> 30;
		t       = 64'd1073741824 - a2 / 64'd72;
		t       = 64'd1073741824 - ((a2 * t) >> 30) / 64'd42;
		t       = 64'd1073741824 - ((a2 * t) >> 30) / 64'd20;
		t       = 64'd1073741824 - ((a2 * t) >> 30) / 64'd6;
		s       = (ang * t) >> 30;
		mag     = (s + 64'd8192) >> 14;
		if (mag > 64'd65536) begin
			mag = 64'd65536;
		end
		if (quad < 64'd2) begin
			res = 64'd32768 + (mag >> 1);
		end else begin
			res = 64'd32768 - (mag >> 1);
		end
		return res[16:0];
	endfunction

endpackage

@@ design/srpg_div.sv @@
module srpg_div #(
	parameter int NUM_W  = 49,
	parameter int DEN_W  = 13,
	parameter int Q_W    = 16,
	parameter int STAGES = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo
);

	localparam int SPS = (NUM_W + STAGES - 1) / STAGES;
	localparam int TOT = SPS * STAGES;

	logic             vld_sn [STAGES];
	logic [DEN_W-1:0] rem_sn [STAGES];
	logic [TOT-1:0]   num_sn [STAGES];
	logic [Q_W-1:0]   quo_sn [STAGES];

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		logic             p_vld;
		logic [DEN_W-1:0] p_rem;
		logic [TOT-1:0]   p_num;
		logic [Q_W-1:0]   p_quo;
		logic [DEN_W-1:0] n_rem;
		logic [TOT-1:0]   n_num;
		logic [Q_W-1:0]   n_quo;

		if (s == 0) begin : g_first
			assign p_vld = in_valid;
			assign p_rem = '0;
			assign p_num = TOT'(num);
			assign p_quo = '0;
		end else begin : g_next
			assign p_vld = vld_sn[s-1];
			assign p_rem = rem_sn[s-1];
			assign p_num = num_sn[s-1];
			assign p_quo = quo_sn[s-1];
		end

		always_comb begin : step_c
			logic [DEN_W:0] t;
			logic [DEN_W-1:0] r;
			logic [TOT-1:0] nm;
			logic [Q_W-1:0] q;
			r  = p_rem;
			nm = p_num;
			q  = p_quo;
			for (int i = 0; i < SPS; i++) begin
				t  = {r, nm[TOT-1]};
				nm = nm << 1;
				if (t >= {1'b0, den}) begin
					t = t - {1'b0, den};
					q = {q[Q_W-2:0], 1'b1};
				end else begin
					q = {q[Q_W-2:0], 1'b0};
				end
				r = t[DEN_W-1:0];
			end
			n_rem = r;
			n_num = nm;
			n_quo = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[s] <= 1'b0;
			end else begin
				vld_sn[s] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[s] <= n_rem;
			num_sn[s] <= n_num;
			quo_sn[s] <= n_quo;
		end
	end

	assign out_valid = vld_sn[STAGES-1];
	assign quo       = quo_sn[STAGES-1];

endmodule

@@ design/scrolling_rainbow_pattern_generator.sv @@
// Scrolling rainbow test pattern: one BGRA pixel per transaction, one transaction per clock.
// Each result appears on blue/green/red/alpha with strobe after start is taken and the pixel
// has passed the input, multiply and sum registers, the two 13-stage long dividers (by
// frame_height for the hue, by frame_width for the sine index) and then the lookup, blend
// and output registers; busy stays low, so a new pixel may be started in every cycle.
// Results cannot be held off by the receiver. Register writes must only happen while no
// pixel is in flight; zero width or height acts as one.
module scrolling_rainbow_pattern_generator #(
	parameter int DIM_BITS        = 12,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [DIM_BITS-1:0]                pixel_x,
	input  logic [DIM_BITS-1:0]                pixel_y,
	input  logic [srpg_pkg::TIME_W-1:0]        frame_time,
	output logic                               strobe,
	output logic [7:0]                         blue,
	output logic [7:0]                         green,
	output logic [7:0]                         red,
	output logic [7:0]                         alpha,
	input  logic                               cfg_we,
	input  logic [srpg_pkg::ADDR_W-1:0]        cfg_addr,
	input  logic [srpg_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int N_SIN  = 1 << SINE_TABLE_BITS;
	localparam int XNUM_W = DIM_BITS + SINE_TABLE_BITS;
	localparam int PROD_W = srpg_pkg::TIME_W + srpg_pkg::SPEED_W;

	logic [srpg_pkg::CFG_W-1:0]   frame_width_q;
	logic [srpg_pkg::CFG_W-1:0]   frame_height_q;
	logic [srpg_pkg::SPEED_W-1:0] scroll_speed_q;
	logic [srpg_pkg::CFG_W-1:0]   wdiv;
	logic [srpg_pkg::CFG_W-1:0]   hdiv;

	logic                         accept;
	logic                         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [DIM_BITS-1:0]          px_s1, py_s1, px_s2, py_s2, px_s3;
	logic [srpg_pkg::TIME_W-1:0]  tm_s1;
	logic [PROD_W-1:0]            prod_s2;
	logic [srpg_pkg::SUM_W-1:0]   sum_s3;
	logic [srpg_pkg::TFRAC_W-1:0] low_s3;

	logic                         ydiv_vld, xdiv_vld;
	logic [srpg_pkg::FRAC_W-1:0]  ty;
	logic [SINE_TABLE_BITS-1:0]   kidx;

	logic [16:0]                  sat_rom [N_SIN];
	logic [18:0]                  hue;
	logic [16:0]                  f_c, q_c;
	logic [16:0]                  r_c, g_c, b_c;
	logic [16:0]                  r_s4, g_s4, b_s4, sat_s4;
	logic [16:0]                  vr_s5, vg_s5, vb_s5;
	logic [7:0]                   r_s6, g_s6, b_s6;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign wdiv   = (frame_width_q == '0) ? srpg_pkg::CFG_W'(1) : frame_width_q;
	assign hdiv   = (frame_height_q == '0) ? srpg_pkg::CFG_W'(1) : frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= srpg_pkg::RST_FRAME_WIDTH;
			frame_height_q <= srpg_pkg::RST_FRAME_HEIGHT;
			scroll_speed_q <= srpg_pkg::RST_SCROLL_SPEED;
		end else if (cfg_we) begin
			case (srpg_pkg::cfg_idx_t'(cfg_addr))
				srpg_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				srpg_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				srpg_pkg::CFG_SCROLL_SPEED: scroll_speed_q <= cfg_wdata[srpg_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= ydiv_vld & xdiv_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= pixel_x;
		py_s1   <= pixel_y;
		tm_s1   <= frame_time;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		prod_s2 <= PROD_W'(tm_s1) * PROD_W'(scroll_speed_q);
		px_s3   <= px_s2;
		sum_s3  <= srpg_pkg::SUM_W'(py_s2) +
			srpg_pkg::SUM_W'(prod_s2[PROD_W-1:srpg_pkg::TFRAC_W]);
		low_s3  <= prod_s2[srpg_pkg::TFRAC_W-1:0];
	end

	srpg_div #(
		.NUM_W  (srpg_pkg::YNUM_W),
		.DEN_W  (srpg_pkg::CFG_W),
		.Q_W    (srpg_pkg::FRAC_W),
		.STAGES (srpg_pkg::DIV_STAGES)
	) u_ydiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.num       ({sum_s3, low_s3, 6'd0}),
		.den       (hdiv),
		.out_valid (ydiv_vld),
		.quo       (ty)
	);

	srpg_div #(
		.NUM_W  (XNUM_W),
		.DEN_W  (srpg_pkg::CFG_W),
		.Q_W    (SINE_TABLE_BITS),
		.STAGES (srpg_pkg::DIV_STAGES)
	) u_xdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.num       ({px_s3, SINE_TABLE_BITS'(0)}),
		.den       (wdiv),
		.out_valid (xdiv_vld),
		.quo       (kidx)
	);

	for (genvar i = 0; i < N_SIN; i++) begin : g_rom
		assign sat_rom[i] = srpg_pkg::sat_entry(i, SINE_TABLE_BITS);
	end

	assign hue = 19'(ty) * 19'd6;
	assign f_c = {1'b0, hue[15:0]};
	assign q_c = srpg_pkg::Q16_ONE - f_c;

	always_comb begin
		case (srpg_pkg::sector_t'(hue[18:16]))
			srpg_pkg::SECT_RED_GREEN_UP: begin
				r_c = srpg_pkg::Q16_ONE; g_c = f_c; b_c = '0;
			end
			srpg_pkg::SECT_RED_DOWN: begin
				r_c = q_c; g_c = srpg_pkg::Q16_ONE; b_c = '0;
			end
			srpg_pkg::SECT_BLUE_UP: begin
				r_c = '0; g_c = srpg_pkg::Q16_ONE; b_c = f_c;
			end
			srpg_pkg::SECT_GREEN_DOWN: begin
				r_c = '0; g_c = q_c; b_c = srpg_pkg::Q16_ONE;
			end
			srpg_pkg::SECT_RED_UP: begin
				r_c = f_c; g_c = '0; b_c = srpg_pkg::Q16_ONE;
			end
			default: begin
				r_c = srpg_pkg::Q16_ONE; g_c = '0; b_c = q_c;
			end
		endcase
	end

	function automatic logic [16:0] blend(input logic [16:0] c, input logic [16:0] sat);
		logic [34:0] v;
		v = 35'(c) * 35'(sat) + (35'(srpg_pkg::Q16_ONE - sat) << 15);
		return v[32:16];
	endfunction

	function automatic logic [7:0] to_byte(input logic [16:0] v);
		logic [24:0] p;
		p = (25'(v) << 8) - 25'(v);
		return p[23:16];
	endfunction

	always_ff @(posedge clk) begin
		r_s4   <= r_c;
		g_s4   <= g_c;
		b_s4   <= b_c;
		sat_s4 <= sat_rom[kidx];
		vr_s5  <= blend(r_s4, sat_s4);
		vg_s5  <= blend(g_s4, sat_s4);
		vb_s5  <= blend(b_s4, sat_s4);
		r_s6   <= to_byte(vr_s5);
		g_s6   <= to_byte(vg_s5);
		b_s6   <= to_byte(vb_s5);
	end

	assign strobe = vld_s6;
	assign red    = r_s6;
	assign green  = g_s6;
	assign blue   = b_s6;
	assign alpha  = srpg_pkg::ALPHA_OPAQUE;

endmodule

@@ design/srpg_chk.sv @@
module srpg_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] alpha
);

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> alpha == srpg_pkg::ALPHA_OPAQUE)
		else $error("alpha not opaque");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(srpg_pkg::LATENCY) strobe)
		else $error("transaction produced no result");

	a_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, srpg_pkg::LATENCY))
		else $error("result without transaction");

endmodule

bind scrolling_rainbow_pattern_generator srpg_chk u_srpg_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.alpha  (alpha)
);

@@ bench/scrolling_rainbow_pattern_generator_test.sv @@
module scrolling_rainbow_pattern_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM_BITS        = 12;
	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_N          = 1 << SINE_TABLE_BITS;
	localparam int CYCLE_LIMIT     = 400000;
	localparam logic [srpg_pkg::ADDR_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} bgra_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [DIM_BITS-1:0]           pixel_x;
	logic [DIM_BITS-1:0]           pixel_y;
	logic [srpg_pkg::TIME_W-1:0]   frame_time;
	logic                          strobe;
	logic [7:0]                    blue;
	logic [7:0]                    green;
	logic [7:0]                    red;
	logic [7:0]                    alpha;
	logic                          cfg_we;
	logic [srpg_pkg::ADDR_W-1:0]   cfg_addr;
	logic [srpg_pkg::CFG_W-1:0]    cfg_wdata;

	logic [srpg_pkg::CFG_W-1:0]    width_reg;
	logic [srpg_pkg::CFG_W-1:0]    height_reg;
	logic [srpg_pkg::SPEED_W-1:0]  speed_reg;
	logic [16:0]                   sat_lut [SINE_N];
	bgra_t                         pixel_queue [$];
	logic                          busy_seen;
	int                            burst_left;
	int                            err_count;
	int                            pixels_sent;
	int                            pixels_checked;
	int                            cycle_count;

	scrolling_rainbow_pattern_generator #(
		.DIM_BITS(DIM_BITS),
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.frame_time(frame_time),
		.strobe(strobe),
		.blue(blue),
		.green(green),
		.red(red),
		.alpha(alpha),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [16:0] saturation_of(int k);
		longint unsigned quad, r, m, ang, a2, t, s, mag;
		quad = k >> (SINE_TABLE_BITS - 2);
		r    = k & (SINE_N / 4 - 1);
		m    = quad[0] ? (SINE_N / 4 - r) : r;
		ang  = (m * 64'd6746518852) >> SINE_TABLE_BITS;
		a2   = (ang * ang) >> 30;
		t    = 64'd1073741824 - a2 / 72;
		t    = 64'd1073741824 - ((a2 * t) >> 30) / 42;
		t    = 64'd1073741824 - ((a2 * t) >> 30) / 20;
		t    = 64'd1073741824 - ((a2 * t) >> 30) / 6;
		s    = (ang * t) >> 30;
		mag  = (s + 64'd8192) >> 14;
		if (mag > 64'd65536) begin
			mag = 64'd65536;
		end
		return (quad < 2) ? 17'(32768 + (mag >> 1)) : 17'(32768 - (mag >> 1));
	endfunction

	function automatic logic [7:0] channel_byte(longint unsigned c, longint unsigned sat);
		longint unsigned v;
		v = (c * sat + (65536 - sat) * 32768) >> 16;
		return 8'((v * 255) >> 16);
	endfunction

	function automatic bgra_t rainbow_pixel(logic [DIM_BITS-1:0] px, logic [DIM_BITS-1:0] py,
			logic [srpg_pkg::TIME_W-1:0] tm);
		longint unsigned w, h, span, offs, pos, ty, hue, f, q, r, g, b, sat;
		bgra_t p;
		w    = (width_reg == 0) ? 1 : width_reg;
		h    = (height_reg == 0) ? 1 : height_reg;
		span = h << 10;
		offs = (longint'(tm) * speed_reg) % span;
		pos  = ((longint'(py) << 10) + offs) % span;
		ty   = (pos * 64) / h;
		hue  = ty * 6;
		f    = hue & 16'hFFFF;
		q    = 65536 - f;
		case (srpg_pkg::sector_t'(hue[18:16]))
			srpg_pkg::SECT_RED_GREEN_UP: begin r = 65536; g = f;     b = 0;     end
			srpg_pkg::SECT_RED_DOWN:     begin r = q;     g = 65536; b = 0;     end
			srpg_pkg::SECT_BLUE_UP:      begin r = 0;     g = 65536; b = f;     end
			srpg_pkg::SECT_GREEN_DOWN:   begin r = 0;     g = q;     b = 65536; end
			srpg_pkg::SECT_RED_UP:       begin r = f;     g = 0;     b = 65536; end
			default:                     begin r = 65536; g = 0;     b = q;     end
		endcase
		sat     = sat_lut[((longint'(px) * SINE_N) / w) % SINE_N];
		p.blue  = channel_byte(b, sat);
		p.green = channel_byte(g, sat);
		p.red   = channel_byte(r, sat);
		p.alpha = srpg_pkg::ALPHA_OPAQUE;
		return p;
	endfunction

	always @(negedge clk) begin
		busy_seen <= busy;
	end

	always @(posedge clk) begin
		bgra_t want;
		if (strobe) begin
			if (pixel_queue.size() == 0) begin
				$error("unexpected pixel: b=%0d g=%0d r=%0d a=%0d", blue, green, red, alpha);
				err_count++;
			end else begin
				want = pixel_queue.pop_front();
				pixels_checked++;
				if (blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, blue);
					err_count++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, green);
					err_count++;
				end
				if (red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, red);
					err_count++;
				end
				if (alpha !== want.alpha) begin
					$error("alpha: expected %0d, got %0d", want.alpha, alpha);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_pixel(logic [DIM_BITS-1:0] px, logic [DIM_BITS-1:0] py,
			logic [srpg_pkg::TIME_W-1:0] tm);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			                                           : $urandom_range(1, 12);
		end
		start      <= 1'b1;
		pixel_x    <= px;
		pixel_y    <= py;
		frame_time <= tm;
		do @(posedge clk); while (busy_seen);
		pixel_queue.push_back(rainbow_pixel(px, py, tm));
		pixels_sent++;
		burst_left--;
	endtask

	task automatic drain;
		start      <= 1'b0;
		burst_left = 0;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (srpg_pkg::LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_cfg(logic [srpg_pkg::ADDR_W-1:0] addr,
			logic [srpg_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		case (addr)
			srpg_pkg::CFG_FRAME_WIDTH:  width_reg  = data;
			srpg_pkg::CFG_FRAME_HEIGHT: height_reg = data;
			srpg_pkg::CFG_SCROLL_SPEED: speed_reg  = data[srpg_pkg::SPEED_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(int w, int h, int spd);
		drain();
		write_cfg(srpg_pkg::CFG_FRAME_WIDTH, srpg_pkg::CFG_W'(w));
		write_cfg(srpg_pkg::CFG_FRAME_HEIGHT, srpg_pkg::CFG_W'(h));
		write_cfg(srpg_pkg::CFG_SCROLL_SPEED, srpg_pkg::CFG_W'(spd));
	endtask

	task automatic test_reset_defaults;
		int hue_rows [6] = '{0, 86, 171, 256, 342, 427};
		foreach (hue_rows[i]) begin
			send_pixel(DIM_BITS'(i * 80), DIM_BITS'(hue_rows[i]), 32'd0);
		end
		send_pixel('0, '0, '1);
		send_pixel('1, '1, '1);
		send_pixel(12'd128, 12'd511, 32'd1024);
		send_pixel(12'd384, 12'd300, 32'h5555_5555);
	endtask

	task automatic test_field_extremes;
		set_frame(4096, 4096, 1023);
		send_pixel('0, '0, '0);
		send_pixel('1, '1, '1);
		send_pixel(12'hAAA, 12'h555, 32'hAAAA_AAAA);
		send_pixel(12'h555, 12'hAAA, 32'h5555_5555);
		set_frame(0, 0, 0);
		send_pixel('1, '1, '1);
		send_pixel(12'd1, 12'd0, 32'd77);
		set_frame(8191, 8191, 1023);
		send_pixel('1, '1, '1);
		send_pixel(12'd2047, 12'd100, 32'h8000_0000);
		set_frame(1, 1, 5);
		send_pixel(12'd4095, 12'd4095, 32'd12345);
		drain();
		write_cfg(CFG_UNUSED, '1);
		send_pixel(12'd3, 12'd0, 32'd0);
	endtask

	task automatic random_phase(int w, int h, int spd, int count);
		int px, py;
		set_frame(w, h, spd);
		repeat (count) begin
			px = ($urandom_range(0, 3) != 0 && w > 0) ? $urandom_range(0, (w > 4096 ? 4096 : w) - 1)
			                                          : $urandom_range(0, 4095);
			py = ($urandom_range(0, 3) != 0 && h > 0) ? $urandom_range(0, (h > 4096 ? 4096 : h) - 1)
			                                          : $urandom_range(0, 4095);
			send_pixel(DIM_BITS'(px), DIM_BITS'(py), srpg_pkg::TIME_W'($urandom()));
		end
	endtask

	task automatic test_random_frames;
		random_phase(512, 512, 80, 250);
		random_phase(4096, 4096, 1023, 200);
		random_phase(1, 1, 0, 100);
		random_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 1023), 250);
		random_phase(8191, $urandom_range(2, 64), $urandom_range(0, 1023), 200);
		random_phase($urandom_range(2, 64), 8191, 1023, 200);
		random_phase(0, 0, $urandom_range(0, 1023), 100);
		random_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 1023), 350);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		pixel_x    = '0;
		pixel_y    = '0;
		frame_time = '0;
		cfg_we     = 1'b0;
		cfg_addr   = srpg_pkg::CFG_FRAME_WIDTH;
		cfg_wdata  = '0;
		width_reg  = srpg_pkg::RST_FRAME_WIDTH;
		height_reg = srpg_pkg::RST_FRAME_HEIGHT;
		speed_reg  = srpg_pkg::RST_SCROLL_SPEED;
		burst_left = 0;
		for (int k = 0; k < SINE_N; k++) begin
			sat_lut[k] = saturation_of(k);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_random_frames();
		drain();

		if (pixel_queue.size() != 0) begin
			$error("%0d pixels never arrived", pixel_queue.size());
			err_count++;
		end
		$display("Sent %0d pixels over frame sizes from zero to 8191 and speeds 0 to 1023;",
			pixels_sent);
		$display("%0d pixels checked, %0d mismatches.", pixels_checked, err_count);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
